@@ hdl/spi_mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI master byte engine package
// Operation codes, register indexes and limits shared by the engine and its
// checker.
// ----------------------------------------------------------------------------
package spi_mbe_pkg;

    localparam int NUM_DEVICES = 4;
    localparam int DEV_W       = 3;
    localparam int HOLD_W      = 8;
    localparam int DATA_W      = 8;
    localparam int BIT_CNT_W   = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [HOLD_W-1:0] MIN_HOLD   = HOLD_W'(10);
    localparam logic [HOLD_W-1:0] RESET_HOLD = HOLD_W'(10);

    typedef enum logic [1:0] {
        OP_IDLE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_SELECT = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TIME        = 1'b0,
        REG_SAMPLE_ON_RISING = 1'b1
    } t_reg_idx;

endpackage

@@ hdl/spi_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// SPI master byte engine
// Bit-serial SPI master moving one byte at a time, MSB first, paced by one
// input word per microsecond tick.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+----------------------
//   input    | in        | i_in_valid / o_in_stall    | tick and command
//   output   | out       | o_out_valid / i_out_stall  | line levels and status
//   config   | in        | i_cfg_we                   | index and data
//
// Each input word updates the state at the accepting edge, and its result
// word sits in the output register on the next cycle.
// A new word is taken every cycle unless a waiting result is stalled.
// Reset is synchronous and returns the engine to idle with no device selected.
// ----------------------------------------------------------------------------
module spi_master_byte_engine
    import spi_mbe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_operation,
    input  logic [DATA_W-1:0]    i_write_data,
    input  logic [DEV_W-1:0]     i_device_number,
    input  logic                 i_sdo_level,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_sclk,
    output logic                 o_sdi,
    output logic [NUM_DEVICES-1:0] o_chip_selects,
    output logic                 o_busy_res,
    output logic [DATA_W-1:0]    o_read_data,
    output logic                 o_read_done,
    output logic                 o_select_ok,
    output logic [DEV_W-1:0]     o_selected_device,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [HOLD_W-1:0]    i_cfg_data
);

    logic [HOLD_W-1:0]    r_hold_time;
    logic                 r_sample_on_rising;

    logic [DATA_W-1:0]    r_shift_reg,      n_shift_reg;
    logic [BIT_CNT_W-1:0] r_bit_count,      n_bit_count;
    logic                 r_half_phase,     n_half_phase;
    logic [HOLD_W-1:0]    r_delay_count,    n_delay_count;
    t_op                  r_active_op,      n_active_op;
    logic                 r_clock_level,    n_clock_level;
    logic                 r_data_level,     n_data_level;
    logic [DEV_W-1:0]     r_current_device, n_current_device;
    logic [DATA_W-1:0]    r_last_read,      n_last_read;
    logic                 r_last_select_ok, n_last_select_ok;
    logic                 n_done;

    logic                 r_out_valid;
    logic                 r_sclk;
    logic                 r_sdi;
    logic [NUM_DEVICES-1:0] r_chip_selects, n_chip_selects;
    logic                 r_busy_res;
    logic [DATA_W-1:0]    r_read_data;
    logic                 r_read_done;
    logic                 r_select_ok;
    logic [DEV_W-1:0]     r_selected_device;

    logic                 in_accept;
    t_op                  in_op;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign in_op      = t_op'(i_operation);

    always_comb begin
        n_shift_reg      = r_shift_reg;
        n_bit_count      = r_bit_count;
        n_half_phase     = r_half_phase;
        n_delay_count    = r_delay_count;
        n_active_op      = r_active_op;
        n_clock_level    = r_clock_level;
        n_data_level     = r_data_level;
        n_current_device = r_current_device;
        n_last_read      = r_last_read;
        n_last_select_ok = r_last_select_ok;
        n_done           = 1'b0;

        if (r_active_op == OP_IDLE) begin
            case (in_op)
                OP_WRITE: begin
                    n_active_op   = OP_WRITE;
                    n_shift_reg   = i_write_data;
                    n_bit_count   = '0;
                    n_data_level  = i_write_data[DATA_W-1];
                    n_half_phase  = 1'b0;
                    n_delay_count = r_hold_time;
                end
                OP_READ: begin
                    n_active_op   = OP_READ;
                    n_shift_reg   = '0;
                    n_bit_count   = '0;
                    n_clock_level = r_sample_on_rising;
                    n_half_phase  = 1'b0;
                    n_delay_count = r_hold_time;
                end
                OP_SELECT: begin
                    if (i_device_number <= DEV_W'(NUM_DEVICES)) begin
                        n_current_device = i_device_number;
                        n_last_select_ok = 1'b1;
                    end else begin
                        n_current_device = '0;
                        n_last_select_ok = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_delay_count > HOLD_W'(1)) begin
            n_delay_count = r_delay_count - HOLD_W'(1);
        end else if (!r_half_phase) begin
            if (r_active_op == OP_READ) begin
                n_shift_reg   = {r_shift_reg[DATA_W-2:0], i_sdo_level};
                n_clock_level = ~r_sample_on_rising;
            end else begin
                n_clock_level = r_sample_on_rising;
            end
            n_half_phase  = 1'b1;
            n_delay_count = r_hold_time;
        end else begin
            if (r_active_op == OP_WRITE) begin
                n_clock_level = ~r_sample_on_rising;
                n_shift_reg   = {r_shift_reg[DATA_W-2:0], 1'b0};
            end
            if (r_bit_count == BIT_CNT_W'(DATA_W - 1)) begin
                if (r_active_op == OP_WRITE) begin
                    n_data_level = 1'b1;
                end else begin
                    n_last_read = r_shift_reg;
                    n_done      = 1'b1;
                end
                n_active_op   = OP_IDLE;
                n_bit_count   = '0;
                n_half_phase  = 1'b0;
                n_delay_count = '0;
            end else begin
                n_bit_count = r_bit_count + BIT_CNT_W'(1);
                if (r_active_op == OP_WRITE) begin
                    n_data_level = r_shift_reg[DATA_W-2];
                end else begin
                    n_clock_level = r_sample_on_rising;
                end
                n_half_phase  = 1'b0;
                n_delay_count = r_hold_time;
            end
        end
    end

    always_comb begin
        n_chip_selects = '0;
        for (int d = 1; d <= NUM_DEVICES; d++) begin
            if (n_current_device == DEV_W'(d)) begin
                n_chip_selects[d-1] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time        <= RESET_HOLD;
            r_sample_on_rising <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_HOLD_TIME: begin
                    if (i_cfg_data >= MIN_HOLD) begin
                        r_hold_time <= i_cfg_data;
                    end
                end
                REG_SAMPLE_ON_RISING: begin
                    r_sample_on_rising <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_reg      <= '0;
            r_bit_count      <= '0;
            r_half_phase     <= 1'b0;
            r_delay_count    <= '0;
            r_active_op      <= OP_IDLE;
            r_clock_level    <= 1'b0;
            r_data_level     <= 1'b1;
            r_current_device <= '0;
            r_last_read      <= '0;
            r_last_select_ok <= 1'b1;
            r_out_valid      <= 1'b0;
        end else begin
            if (in_accept) begin
                r_shift_reg      <= n_shift_reg;
                r_bit_count      <= n_bit_count;
                r_half_phase     <= n_half_phase;
                r_delay_count    <= n_delay_count;
                r_active_op      <= n_active_op;
                r_clock_level    <= n_clock_level;
                r_data_level     <= n_data_level;
                r_current_device <= n_current_device;
                r_last_read      <= n_last_read;
                r_last_select_ok <= n_last_select_ok;
                r_out_valid      <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sclk            <= n_clock_level;
            r_sdi             <= n_data_level;
            r_chip_selects    <= n_chip_selects;
            r_busy_res        <= (n_active_op != OP_IDLE);
            r_read_data       <= n_last_read;
            r_read_done       <= n_done;
            r_select_ok       <= n_last_select_ok;
            r_selected_device <= n_current_device;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sclk            = r_sclk;
    assign o_sdi             = r_sdi;
    assign o_chip_selects    = r_chip_selects;
    assign o_busy_res        = r_busy_res;
    assign o_read_data       = r_read_data;
    assign o_read_done       = r_read_done;
    assign o_select_ok       = r_select_ok;
    assign o_selected_device = r_selected_device;

endmodule

@@ hdl/spi_mbe_checker.sv @@
// ----------------------------------------------------------------------------
// SPI master byte engine checker
// Port-level properties of the engine, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module spi_mbe_checker
    import spi_mbe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_out_stall,
    input  logic                   o_out_valid,
    input  logic                   o_sclk,
    input  logic [NUM_DEVICES-1:0] o_chip_selects,
    input  logic                   o_busy_res,
    input  logic                   o_read_done,
    input  logic                   o_select_ok,
    input  logic [DEV_W-1:0]       o_selected_device
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sclk)
            && $stable(o_busy_res) && $stable(o_selected_device))
        else $error("Stalled result word changed.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_done |-> !o_busy_res)
        else $error("Read completion shown while still busy.");

    a_cs_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_chip_selects)
            && ((o_chip_selects == '0) == (o_selected_device == '0)))
        else $error("Chip selects disagree with the selected device.");

    a_bad_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_select_ok |-> o_selected_device == '0)
        else $error("Rejected select left a device selected.");

endmodule

bind spi_master_byte_engine spi_mbe_checker u_spi_mbe_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_stall       (i_out_stall),
    .o_out_valid       (o_out_valid),
    .o_sclk            (o_sclk),
    .o_chip_selects    (o_chip_selects),
    .o_busy_res        (o_busy_res),
    .o_read_done       (o_read_done),
    .o_select_ok       (o_select_ok),
    .o_selected_device (o_selected_device)
);

@@ tb/tb_spi_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// SPI master byte engine testbench
// Sends tick and command words to the engine with random input gaps and
// output stalls. An independent model of the bit timing predicts each result
// word, and the bench compares every field with that prediction.
// ----------------------------------------------------------------------------
module tb_spi_master_byte_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import spi_mbe_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_OFF    = 64;

    typedef struct packed {
        logic                   sclk;
        logic                   sdi;
        logic [NUM_DEVICES-1:0] cs;
        logic                   busy;
        logic [DATA_W-1:0]      rdata;
        logic                   rdone;
        logic                   sel_ok;
        logic [DEV_W-1:0]       dev;
    } t_line_word;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [1:0]             i_operation;
    logic [DATA_W-1:0]      i_write_data;
    logic [DEV_W-1:0]       i_device_number;
    logic                   i_sdo_level;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_sclk;
    logic                   o_sdi;
    logic [NUM_DEVICES-1:0] o_chip_selects;
    logic                   o_busy_res;
    logic [DATA_W-1:0]      o_read_data;
    logic                   o_read_done;
    logic                   o_select_ok;
    logic [DEV_W-1:0]       o_selected_device;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [HOLD_W-1:0]      i_cfg_data;

    t_op               xfer_op;
    logic [DATA_W-1:0] sh_byte;
    logic [DATA_W-1:0] rd_byte;
    logic [3:0]        bits_done;
    logic              second_half;
    logic [HOLD_W-1:0] ticks_left;
    logic [HOLD_W-1:0] half_ticks;
    logic              rise_first;
    logic              sclk_q;
    logic              sdi_q;
    logic              select_good;
    logic [DEV_W-1:0]  dev_sel;

    t_line_word expected_lines[$];

    int  mismatches      = 0;
    int  words_sent      = 0;
    int  results_checked = 0;
    int  writes_done     = 0;
    int  reads_done      = 0;
    int  selects_taken   = 0;
    int  selects_refused = 0;
    int  quiet_cycles    = 0;
    bit  gaps_on         = 1'b1;
    bit  hold_req        = 1'b0;

    spi_master_byte_engine u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_write_data      (i_write_data),
        .i_device_number   (i_device_number),
        .i_sdo_level       (i_sdo_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sclk            (o_sclk),
        .o_sdi             (o_sdi),
        .o_chip_selects    (o_chip_selects),
        .o_busy_res        (o_busy_res),
        .o_read_data       (o_read_data),
        .o_read_done       (o_read_done),
        .o_select_ok       (o_select_ok),
        .o_selected_device (o_selected_device),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reset_engine_model();
        xfer_op     = OP_IDLE;
        sh_byte     = '0;
        rd_byte     = '0;
        bits_done   = '0;
        second_half = 1'b0;
        ticks_left  = '0;
        half_ticks  = RESET_HOLD;
        rise_first  = 1'b1;
        sclk_q      = 1'b0;
        sdi_q       = 1'b1;
        select_good = 1'b1;
        dev_sel     = '0;
    endfunction

    function automatic void begin_bit();
        if (xfer_op == OP_WRITE) begin
            sdi_q = sh_byte[DATA_W-1];
        end else begin
            sclk_q = rise_first;
        end
        second_half = 1'b0;
        ticks_left  = half_ticks;
    endfunction

    function automatic t_line_word advance_tick(t_op op, logic [DATA_W-1:0] wdata,
                                                logic [DEV_W-1:0] dev, logic sdo);
        t_line_word w;
        logic       r;
        logic       done;
        r    = rise_first;
        done = 1'b0;
        if (xfer_op == OP_IDLE) begin
            if (op == OP_WRITE || op == OP_READ) begin
                xfer_op   = op;
                sh_byte   = (op == OP_WRITE) ? wdata : '0;
                bits_done = '0;
                begin_bit();
            end else if (op == OP_SELECT) begin
                if (dev <= NUM_DEVICES) begin
                    dev_sel     = dev;
                    select_good = 1'b1;
                    selects_taken++;
                end else begin
                    dev_sel     = '0;
                    select_good = 1'b0;
                    selects_refused++;
                end
            end
        end else if (ticks_left > 1) begin
            ticks_left--;
        end else if (!second_half) begin
            if (xfer_op == OP_READ) begin
                sh_byte = {sh_byte[DATA_W-2:0], sdo};
                sclk_q  = ~r;
            end else begin
                sclk_q = r;
            end
            second_half = 1'b1;
            ticks_left  = half_ticks;
        end else begin
            if (xfer_op == OP_WRITE) begin
                sclk_q  = ~r;
                sh_byte = sh_byte << 1;
            end
            bits_done = bits_done + 1'b1;
            if (bits_done >= 8) begin
                if (xfer_op == OP_WRITE) begin
                    sdi_q = 1'b1;
                    writes_done++;
                end else begin
                    rd_byte = sh_byte;
                    done    = 1'b1;
                    reads_done++;
                end
                xfer_op     = OP_IDLE;
                bits_done   = '0;
                second_half = 1'b0;
                ticks_left  = '0;
            end else begin
                begin_bit();
            end
        end
        w.sclk   = sclk_q;
        w.sdi    = sdi_q;
        w.cs     = '0;
        if (dev_sel >= 1 && dev_sel <= NUM_DEVICES) begin
            w.cs[dev_sel - 1] = 1'b1;
        end
        w.busy   = (xfer_op != OP_IDLE);
        w.rdata  = rd_byte;
        w.rdone  = done;
        w.sel_ok = select_good;
        w.dev    = dev_sel;
        return w;
    endfunction

    task automatic send_word(t_op op, logic [DATA_W-1:0] wdata, logic [DEV_W-1:0] dev,
                             logic sdo);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation     = op;
        i_write_data    = wdata;
        i_device_number = dev;
        i_sdo_level     = sdo;
        i_in_valid      = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_lines.push_back(advance_tick(op, wdata, dev, sdo));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic tick_word(logic sdo);
        send_word(OP_IDLE, DATA_W'($urandom), DEV_W'($urandom), sdo);
    endtask

    task automatic run_ticks(int n);
        repeat (n) tick_word(1'($urandom));
    endtask

    // sdo_mode 0 and 1 hold the line at that level, 2 draws it at random.
    task automatic finish_transfer(int sdo_mode);
        while (xfer_op != OP_IDLE) begin
            tick_word((sdo_mode == 2) ? 1'($urandom) : 1'(sdo_mode));
        end
    endtask

    task automatic quiesce();
        i_in_valid = 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [HOLD_W-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        if (idx == REG_HOLD_TIME) begin
            if (data >= MIN_HOLD) half_ticks = data;
        end else begin
            rise_first = data[0];
        end
    endtask

    task automatic random_word();
        int  pick;
        t_op op;
        pick = $urandom_range(0, 99);
        if (xfer_op == OP_IDLE) begin
            op = (pick < 45) ? OP_WRITE : (pick < 80) ? OP_READ :
                 (pick < 95) ? OP_SELECT : OP_IDLE;
        end else begin
            op = (pick < 15) ? t_op'($urandom_range(0, 3)) : OP_IDLE;
        end
        send_word(op, DATA_W'($urandom), DEV_W'($urandom_range(0, 7)), 1'($urandom));
    endtask

    task automatic test_reset_state();
        run_ticks(2);
    endtask

    task automatic test_device_select();
        logic [DEV_W-1:0] order[9] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd6, 3'd4, 3'd7};
        foreach (order[k]) begin
            send_word(OP_SELECT, DATA_W'($urandom), order[k], 1'($urandom));
        end
        run_ticks(1);
    endtask

    task automatic test_write_byte();
        send_word(OP_SELECT, '0, 3'd2, 1'b0);
        send_word(OP_WRITE, 8'hA5, 3'd0, 1'b0);
        send_word(OP_SELECT, 8'h00, 3'd3, 1'b1);
        send_word(OP_READ, 8'hFF, 3'd7, 1'b0);
        send_word(OP_WRITE, 8'h00, 3'd1, 1'b1);
        finish_transfer(2);
    endtask

    task automatic test_read_byte();
        quiesce();
        write_reg(REG_SAMPLE_ON_RISING, 8'h00);
        send_word(OP_READ, 8'hC3, 3'd0, 1'b0);
        finish_transfer(2);
        quiesce();
        write_reg(REG_SAMPLE_ON_RISING, 8'h01);
    endtask

    task automatic test_hold_time();
        quiesce();
        write_reg(REG_HOLD_TIME, 8'd9);
        write_reg(REG_HOLD_TIME, 8'd0);
        send_word(OP_WRITE, 8'h81, 3'd0, 1'b0);
        run_ticks(50);
        quiesce();
        write_reg(REG_HOLD_TIME, 8'd11);
        write_reg(REG_SAMPLE_ON_RISING, 8'h00);
        finish_transfer(2);
        quiesce();
        write_reg(REG_HOLD_TIME, MIN_HOLD);
        write_reg(REG_SAMPLE_ON_RISING, 8'h01);
    endtask

    task automatic test_backpressure();
        quiesce();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        send_word(OP_SELECT, DATA_W'($urandom), 3'd1, 1'b0);
        run_ticks(40);
        gaps_on  = 1'b1;
        finish_transfer(2);
    endtask

    task automatic test_random();
        int n;
        for (int phase = 0; phase < 2; phase++) begin
            quiesce();
            case (phase)
                1: begin
                    write_reg(REG_HOLD_TIME, HOLD_W'($urandom_range(10, 20)));
                    write_reg(REG_HOLD_TIME, HOLD_W'($urandom_range(0, 9)));
                end
                default: write_reg(REG_HOLD_TIME, MIN_HOLD);
            endcase
            write_reg(REG_SAMPLE_ON_RISING, HOLD_W'($urandom));
            gaps_on = (phase != 1);
            n = 0;
            while (n < 80) begin
                random_word();
                n++;
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic match_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_line_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_lines.size() == 0) begin
                $error("result word arrived with nothing expected");
                mismatches++;
            end else begin
                want = expected_lines.pop_front();
                match_field("sclk", want.sclk, o_sclk);
                match_field("sdi", want.sdi, o_sdi);
                match_field("chip_selects", want.cs, o_chip_selects);
                match_field("busy_res", want.busy, o_busy_res);
                match_field("read_data", want.rdata, o_read_data);
                match_field("read_done", want.rdone, o_read_done);
                match_field("select_ok", want.sel_ok, o_select_ok);
                match_field("selected_device", want.dev, o_selected_device);
                results_checked++;
            end
        end
    end

    initial begin
        int n;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_OFF) @(negedge i_clk);
                hold_req = 1'b0;
            end
            n = gaps_on ? $urandom_range(0, 7) : 0;
            if (n > 0) begin
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_operation     = OP_IDLE;
        i_write_data    = '0;
        i_device_number = '0;
        i_sdo_level     = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_HOLD_TIME;
        i_cfg_data      = '0;
        reset_engine_model();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_device_select();
        test_write_byte();
        test_read_byte();
        test_hold_time();
        test_backpressure();
        test_random();

        quiesce();
        repeat (4) @(posedge i_clk);
        if (expected_lines.size() != 0) begin
            $error("%0d expected result words never arrived", expected_lines.size());
            mismatches++;
        end
        $display("Run covered %0d words in and %0d result words checked.",
                 words_sent, results_checked);
        $display("Bytes written: %0d, bytes read: %0d, selects taken/refused: %0d/%0d.",
                 writes_done, reads_done, selects_taken, selects_refused);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
